### rtl/deq_pkg.sv
// Package for the double-ended queue: opcodes, status codes, default sizes
// and the request struct passed from the pointer control to the top level.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

    localparam int DEQ_DEPTH      = 16;
    localparam int DEQ_WORD_WIDTH = 32;

    localparam logic [1:0] OP_PUSH_FRONT = 2'd0;
    localparam logic [1:0] OP_POP_FRONT  = 2'd1;
    localparam logic [1:0] OP_PUSH_REAR  = 2'd2;
    localparam logic [1:0] OP_POP_REAR   = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic       wr_en;
        logic       rd_en;
        logic [1:0] status;
    } deq_req_t;

endpackage

`default_nettype wire

### rtl/deq_ram.sv
// Generic single-port synchronous RAM with registered read data.
// Read data holds its value in cycles without a read. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

`default_nettype wire

### rtl/deq_ctrl.sv
// Front/rear pointers and occupancy count of the ring buffer; turns each
// transferred item into at most one RAM access and a status code. Uses deq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module deq_ctrl
    import deq_pkg::*;
#(
    parameter int DEPTH      = DEQ_DEPTH,
    parameter int WORD_WIDTH = DEQ_WORD_WIDTH
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     accept,
    input  wire logic [1:0]               opcode,
    input  wire logic signed [31:0]       value_in,
    output deq_req_t                      req,
    output logic      [$clog2(DEPTH)-1:0] addr,
    output logic      [WORD_WIDTH-1:0]    wdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [AW-1:0] front_reg, front_next;
    logic [AW-1:0] rear_reg, rear_next;
    logic [CW-1:0] count_reg, count_next;

    logic [AW-1:0] front_inc, front_dec, rear_inc, rear_dec;
    logic          full, empty;
    logic [WORD_WIDTH+31:0] word_ext;

    assign full  = (count_reg == FULL_CNT);
    assign empty = (count_reg == '0);

    assign front_inc = (front_reg == LAST_IDX) ? '0 : front_reg + 1'b1;
    assign front_dec = (front_reg == '0) ? LAST_IDX : front_reg - 1'b1;
    assign rear_inc  = (rear_reg == LAST_IDX) ? '0 : rear_reg + 1'b1;
    assign rear_dec  = (rear_reg == '0) ? LAST_IDX : rear_reg - 1'b1;

    // store keeps the low WORD_WIDTH bits, zero above 32
    assign word_ext = {{WORD_WIDTH{1'b0}}, value_in};
    assign wdata    = word_ext[WORD_WIDTH-1:0];

    always_comb
    begin
        front_next = front_reg;
        rear_next  = rear_reg;
        count_next = count_reg;
        req        = '{wr_en: 1'b0, rd_en: 1'b0, status: ST_OK};
        addr       = front_reg;
        case (opcode)
            OP_PUSH_FRONT:
            begin
                addr = front_dec;
                if (full)
                begin
                    req.status = ST_FULL;
                end
                else if (accept)
                begin
                    req.wr_en  = 1'b1;
                    front_next = front_dec;
                    count_next = count_reg + 1'b1;
                end
            end
            OP_POP_FRONT:
            begin
                addr = front_reg;
                if (empty)
                begin
                    req.status = ST_EMPTY;
                end
                else if (accept)
                begin
                    req.rd_en  = 1'b1;
                    front_next = front_inc;
                    count_next = count_reg - 1'b1;
                end
            end
            OP_PUSH_REAR:
            begin
                addr = rear_reg;
                if (full)
                begin
                    req.status = ST_FULL;
                end
                else if (accept)
                begin
                    req.wr_en  = 1'b1;
                    rear_next  = rear_inc;
                    count_next = count_reg + 1'b1;
                end
            end
            default:
            begin
                addr = rear_dec;
                if (empty)
                begin
                    req.status = ST_EMPTY;
                end
                else if (accept)
                begin
                    req.rd_en  = 1'b1;
                    rear_next  = rear_dec;
                    count_next = count_reg - 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            rear_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            front_reg <= front_next;
            rear_reg  <= rear_next;
            count_reg <= count_next;
        end
    end

    // rear must always sit count slots past front
    logic [CW:0] span;
    logic [AW-1:0] rear_expect;
    assign span        = (CW+1)'(front_reg) + (CW+1)'(count_reg);
    assign rear_expect = (span >= (CW+1)'(DEPTH)) ? AW'(span - (CW+1)'(DEPTH)) : AW'(span);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("occupancy count above depth");

    a_ring_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        rear_reg == rear_expect)
        else $error("rear pointer out of step with front and count");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        req.wr_en |=> count_reg == $past(count_reg) + 1'b1)
        else $error("push did not grow the count");

    a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        req.rd_en |=> count_reg == $past(count_reg) - 1'b1)
        else $error("pop did not shrink the count");

endmodule

`default_nettype wire

### rtl/double_ended_queue.sv
// Double-ended queue of signed words in a single-port ring-buffer RAM.
// A result is registered and appears in the cycle after its input transfer (RAM read).
// Throughput: one item per cycle; input stalls only while a result waits.
// Reset (rst_n, async): queue empty, pointers zero, no result pending.
// RAM contents are not cleared; only written entries are ever read.
// Uses deq_pkg, deq_ctrl and deq_ram.
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue
    import deq_pkg::*;
#(
    parameter int DEPTH      = DEQ_DEPTH,
    parameter int WORD_WIDTH = DEQ_WORD_WIDTH
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         opcode,
    input  wire logic signed [31:0] value_in,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [31:0]      value_out,
    output logic [1:0]              status
);

    deq_req_t                   req;
    logic [$clog2(DEPTH)-1:0]   addr;
    logic [WORD_WIDTH-1:0]      wdata;
    logic [WORD_WIDTH-1:0]      rdata;
    logic                       accept;

    logic       out_valid_reg, out_valid_next;
    logic [1:0] status_reg;
    logic       pop_ok_reg;
    logic [WORD_WIDTH+31:0] rd_ext;

    assign in_stall = out_valid_reg & out_stall;
    assign accept   = in_valid & ~in_stall;

    deq_ctrl #(
        .DEPTH      (DEPTH),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .opcode   (opcode),
        .value_in (value_in),
        .req      (req),
        .addr     (addr),
        .wdata    (wdata)
    );

    deq_ram #(
        .WIDTH (WORD_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (req.wr_en),
        .re    (req.rd_en),
        .addr  (addr),
        .wdata (wdata),
        .rdata (rdata)
    );

    assign out_valid_next = accept | (out_valid_reg & out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= req.status;
            pop_ok_reg <= req.rd_en;
        end
    end

    // RAM read data holds while the result is stalled (no new read issued)
    assign rd_ext    = {32'd0, rdata};
    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign value_out = pop_ok_reg ? $signed(rd_ext[31:0]) : 32'sd0;

    a_no_access_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> !req.wr_en && !req.rd_en)
        else $error("RAM access while result stalled");

    a_result_follows_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("transfer produced no result");

    a_pop_data_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> $stable(rdata))
        else $error("read data changed under a stalled result");

endmodule

`default_nettype wire
